FILE: src/mwdm_pkg.sv
`timescale 1ns / 1ps

package mwdm_pkg;

    localparam int VEL_W      = 8;
    localparam int FS_W       = 8;
    localparam int DEM_W      = 10;
    localparam int MAG_W      = 9;
    localparam int NUM_W      = MAG_W + FS_W;
    localparam int QUO_W      = FS_W;
    localparam int LANES      = 4;
    localparam int DIV_STAGES = QUO_W;
    localparam int LATENCY    = 2 + DIV_STAGES + 1;

    localparam logic [FS_W-1:0] FULL_SCALE_RESET = 8'd100;

    // Wheel lanes, in the order the demands are formed.
    localparam int LANE_FL = 0;
    localparam int LANE_FR = 1;
    localparam int LANE_RL = 2;
    localparam int LANE_RR = 3;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [LANES-1:0]            neg;
        logic [MAG_W-1:0]            max;
        logic [FS_W-1:0]             fs;
        logic                        scale;
    } div_stage_t;

endpackage

FILE: src/mwdm_front.sv
`timescale 1ns / 1ps

module mwdm_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  valid_in,
    input  logic signed [mwdm_pkg::VEL_W-1:0]     vel_x,
    input  logic signed [mwdm_pkg::VEL_W-1:0]     vel_y,
    input  logic signed [mwdm_pkg::VEL_W-1:0]     rot_z,
    input  logic        [mwdm_pkg::FS_W-1:0]      full_scale,
    output logic                                  valid_out,
    output mwdm_pkg::div_stage_t                  stage_out
);

    localparam int EXT = mwdm_pkg::DEM_W - mwdm_pkg::VEL_W;

    logic signed [mwdm_pkg::DEM_W-1:0] vx_e;
    logic signed [mwdm_pkg::DEM_W-1:0] vy_e;
    logic signed [mwdm_pkg::DEM_W-1:0] wz_e;
    logic signed [mwdm_pkg::DEM_W-1:0] dem [mwdm_pkg::LANES];
    logic [mwdm_pkg::LANES-1:0][mwdm_pkg::DEM_W-1:0] abs_full;

    logic                                                v1_reg;
    logic [mwdm_pkg::LANES-1:0][mwdm_pkg::MAG_W-1:0]     mag1_reg;
    logic [mwdm_pkg::LANES-1:0][mwdm_pkg::MAG_W-1:0]     mag1_next;
    logic [mwdm_pkg::LANES-1:0]                          neg1_reg;
    logic [mwdm_pkg::LANES-1:0]                          neg1_next;
    logic [mwdm_pkg::FS_W-1:0]                           fs1_reg;

    logic [mwdm_pkg::MAG_W-1:0]                          max_a;
    logic [mwdm_pkg::MAG_W-1:0]                          max_b;
    logic [mwdm_pkg::MAG_W-1:0]                          max_all;
    logic                                                v2_reg;
    mwdm_pkg::div_stage_t                                s2_reg;
    mwdm_pkg::div_stage_t                                s2_next;

    // Stage one: the four demands, split into magnitude and sign.
    always_comb
    begin
        vx_e = {{EXT{vel_x[mwdm_pkg::VEL_W-1]}}, vel_x};
        vy_e = {{EXT{vel_y[mwdm_pkg::VEL_W-1]}}, vel_y};
        wz_e = {{EXT{rot_z[mwdm_pkg::VEL_W-1]}}, rot_z};
        dem[mwdm_pkg::LANE_FL] = vy_e - vx_e - wz_e;
        dem[mwdm_pkg::LANE_FR] = vy_e + vx_e + wz_e;
        dem[mwdm_pkg::LANE_RL] = vy_e + vx_e - wz_e;
        dem[mwdm_pkg::LANE_RR] = vy_e - vx_e + wz_e;
        for (int i = 0; i < mwdm_pkg::LANES; i++)
        begin
            neg1_next[i] = dem[i][mwdm_pkg::DEM_W-1];
            abs_full[i]  = neg1_next[i] ? -dem[i] : dem[i];
            mag1_next[i] = abs_full[i][mwdm_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg <= mag1_next;
        neg1_reg <= neg1_next;
        fs1_reg  <= full_scale;
    end

    // Stage two: largest magnitude, the scaling decision and the dividends.
    always_comb
    begin
        max_a   = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
        max_b   = (mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3];
        max_all = (max_a > max_b) ? max_a : max_b;
        s2_next.max   = max_all;
        s2_next.fs    = fs1_reg;
        s2_next.scale = max_all > {1'b0, fs1_reg};
        s2_next.mag   = mag1_reg;
        s2_next.neg   = neg1_reg;
        s2_next.quo   = '0;
        for (int i = 0; i < mwdm_pkg::LANES; i++)
        begin
            s2_next.rem[i] = {{mwdm_pkg::FS_W{1'b0}}, mag1_reg[i]}
                           * {{mwdm_pkg::MAG_W{1'b0}}, fs1_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    assign valid_out = v2_reg;
    assign stage_out = s2_reg;

    a_max_covers_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (s2_reg.max >= s2_reg.mag[0]) && (s2_reg.max >= s2_reg.mag[1])
                && (s2_reg.max >= s2_reg.mag[2]) && (s2_reg.max >= s2_reg.mag[3]))
        else $error("largest magnitude below a lane magnitude");

endmodule

FILE: src/mwdm_divider.sv
`timescale 1ns / 1ps

module mwdm_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  mwdm_pkg::div_stage_t  stage_in,
    output logic                  valid_out,
    output mwdm_pkg::div_stage_t  stage_out
);

    localparam int NS = mwdm_pkg::DIV_STAGES;

    mwdm_pkg::div_stage_t link [NS+1];
    mwdm_pkg::div_stage_t pipe_reg [NS];
    mwdm_pkg::div_stage_t pipe_next [NS];
    logic [NS:0]          vlink;
    logic [NS-1:0]        v_reg;

    assign link[0]  = stage_in;
    assign vlink[0] = valid_in;

    // One quotient bit per stage, most significant first. The dividend is
    // below 256 times the divisor, so eight steps always suffice.
    for (genvar k = 0; k < NS; k++)
    begin : g_step
        localparam int BIT = mwdm_pkg::QUO_W - 1 - k;

        logic [mwdm_pkg::NUM_W-1:0] dsr;

        assign dsr = {{mwdm_pkg::FS_W{1'b0}}, link[k].max} << BIT;

        always_comb
        begin
            pipe_next[k] = link[k];
            for (int i = 0; i < mwdm_pkg::LANES; i++)
            begin
                if (link[k].rem[i] >= dsr)
                begin
                    pipe_next[k].rem[i]      = link[k].rem[i] - dsr;
                    pipe_next[k].quo[i][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            pipe_reg[k] <= pipe_next[k];
        end

        assign link[k+1]  = pipe_reg[k];
        assign vlink[k+1] = v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= vlink[NS-1:0];
        end
    end

    assign valid_out = vlink[NS];
    assign stage_out = link[NS];

    a_quotient_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && stage_out.scale) |->
            (stage_out.quo[0] <= stage_out.fs) && (stage_out.quo[1] <= stage_out.fs)
         && (stage_out.quo[2] <= stage_out.fs) && (stage_out.quo[3] <= stage_out.fs))
        else $error("scaled demand exceeds full scale");

    a_remainder_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && stage_out.scale) |->
            (stage_out.rem[0] < {{mwdm_pkg::FS_W{1'b0}}, stage_out.max})
         && (stage_out.rem[1] < {{mwdm_pkg::FS_W{1'b0}}, stage_out.max})
         && (stage_out.rem[2] < {{mwdm_pkg::FS_W{1'b0}}, stage_out.max})
         && (stage_out.rem[3] < {{mwdm_pkg::FS_W{1'b0}}, stage_out.max}))
        else $error("division left a remainder not below the divisor");

endmodule

FILE: src/mwdm_output.sv
`timescale 1ns / 1ps

module mwdm_output
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          valid_in,
    input  mwdm_pkg::div_stage_t                          stage_in,
    output logic                                          valid_out,
    output logic [mwdm_pkg::LANES-1:0][mwdm_pkg::FS_W-1:0] compare,
    output logic [mwdm_pkg::LANES-1:0]                    dir
);

    logic [mwdm_pkg::LANES-1:0][mwdm_pkg::QUO_W-1:0] qeff;
    logic [mwdm_pkg::LANES-1:0][mwdm_pkg::FS_W-1:0]  cmp_next;
    logic [mwdm_pkg::LANES-1:0][mwdm_pkg::FS_W-1:0]  cmp_reg;
    logic [mwdm_pkg::LANES-1:0]                      dir_next;
    logic [mwdm_pkg::LANES-1:0]                      dir_reg;
    logic                                            v_reg;

    // Unscaled magnitudes never exceed full scale, so they fit in eight bits.
    // A negative demand that truncates to zero counts as forward.
    always_comb
    begin
        for (int i = 0; i < mwdm_pkg::LANES; i++)
        begin
            qeff[i]     = stage_in.scale ? stage_in.quo[i]
                                         : stage_in.mag[i][mwdm_pkg::QUO_W-1:0];
            cmp_next[i] = stage_in.fs - qeff[i];
            dir_next[i] = !stage_in.neg[i] || (qeff[i] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg <= cmp_next;
        dir_reg <= dir_next;
    end

    assign valid_out = v_reg;
    assign compare   = cmp_reg;
    assign dir       = dir_reg;

endmodule

FILE: src/mecanum_wheel_duty_mixer_core.sv
// A command accepted at one clock edge has its result on the outputs, with done
// high, for a single cycle, after the registers of two front stages, eight divider
// stages and one output stage. Throughput: one command per cycle; busy never rises.
// Reset (rst_n low, asynchronous) empties the pipeline and sets full_scale to 100.
// The receiver cannot stall: it must take every result in the cycle done is high (not enforced).
`timescale 1ns / 1ps

module mecanum_wheel_duty_mixer_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [mwdm_pkg::VEL_W-1:0]  vel_x,
    input  logic signed [mwdm_pkg::VEL_W-1:0]  vel_y,
    input  logic signed [mwdm_pkg::VEL_W-1:0]  rot_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [mwdm_pkg::FS_W-1:0]   cfg_data,
    output logic                               done,
    output logic        [mwdm_pkg::FS_W-1:0]   rear_left_compare,
    output logic        [mwdm_pkg::FS_W-1:0]   rear_right_compare,
    output logic        [mwdm_pkg::FS_W-1:0]   front_right_compare,
    output logic        [mwdm_pkg::FS_W-1:0]   front_left_compare,
    output logic                               front_left_dir,
    output logic                               front_right_dir,
    output logic                               rear_left_dir,
    output logic                               rear_right_dir
);

    logic [mwdm_pkg::FS_W-1:0]                          full_scale_reg;
    logic                                               accept;
    logic                                               front_valid;
    mwdm_pkg::div_stage_t                               front_stage;
    logic                                               div_valid;
    mwdm_pkg::div_stage_t                               div_stage;
    logic [mwdm_pkg::LANES-1:0][mwdm_pkg::FS_W-1:0]     compare;
    logic [mwdm_pkg::LANES-1:0]                         dir;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= mwdm_pkg::FULL_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            full_scale_reg <= cfg_data;
        end
    end

    mwdm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (accept),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .rot_z      (rot_z),
        .full_scale (full_scale_reg),
        .valid_out  (front_valid),
        .stage_out  (front_stage)
    );

    mwdm_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (front_valid),
        .stage_in  (front_stage),
        .valid_out (div_valid),
        .stage_out (div_stage)
    );

    mwdm_output u_output
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (div_valid),
        .stage_in  (div_stage),
        .valid_out (done),
        .compare   (compare),
        .dir       (dir)
    );

    // Channel routing keeps the crossed front direction pins.
    assign rear_left_compare   = compare[mwdm_pkg::LANE_RL];
    assign rear_right_compare  = compare[mwdm_pkg::LANE_RR];
    assign front_right_compare = compare[mwdm_pkg::LANE_FR];
    assign front_left_compare  = compare[mwdm_pkg::LANE_FL];
    assign front_left_dir      = dir[mwdm_pkg::LANE_FR];
    assign front_right_dir     = dir[mwdm_pkg::LANE_FL];
    assign rear_left_dir       = dir[mwdm_pkg::LANE_RL];
    assign rear_right_dir      = dir[mwdm_pkg::LANE_RR];

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, mwdm_pkg::LATENCY))
        else $error("result strobe without a matching accepted command");

endmodule
